@@ rtl/core/ocwm_pkg.sv @@
// constants, types and helpers shared by the occlusion class weighted merge core
`default_nettype none

package ocwm_pkg;

    localparam int NUM_REFS         = 4;
    localparam int SAMPLE_BITS      = 10;
    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int NUM_COMPONENTS   = 3;

    localparam int NUM_CLASSES = 1 << NUM_REFS;
    localparam int ROW_DEPTH   = NUM_COMPONENTS * NUM_CLASSES;
    localparam int ROW_AW      = $clog2(ROW_DEPTH);

    localparam int WEIGHT_W = 16;
    localparam int COMP_W   = 2;
    localparam int WREF_W   = 2;
    localparam int ACT_W    = 3;
    localparam int PROD_W   = WEIGHT_W + SAMPLE_BITS + 1;
    localparam int SUM_W    = PROD_W + $clog2(NUM_REFS) + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_ACTIVE_REFS = '0;
    localparam logic [ACT_W-1:0]   ACTIVE_REFS_RST = ACT_W'(4);

    localparam logic ACT_MERGE = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    typedef logic [SAMPLE_BITS-1:0]     sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic [NUM_REFS-1:0]        refmask_t;

    function automatic refmask_t active_mask(input logic [ACT_W-1:0] active);
        refmask_t m;
        for (int k = 0; k < NUM_REFS; k++)
        begin
            m[k] = (int'(active) > k);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ocwm_ram.sv @@
// generic single-write, registered-read ram
`default_nettype none

module ocwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/occlusion_class_weighted_merge_core.sv @@
// top level of the occlusion class weighted merge core
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: items, s_tuser: action
//  m_*       out  m_tvalid/m_tready  m_tdata: merged sample
//  apb       in   psel/penable       active_refs at byte address 0
//
//  one item per cycle while s_tready is high; a merge result is registered after
//  the four weight rams read at the input beat, then after the multiply, sum and clamp
//  stages; a load writes its ram at the input beat and gives no result
//  reset clears the per-entry valid bits so the table reads as zero at once
//  s_tready drops only when every stage and the output register hold a beat
`default_nettype none

module occlusion_class_weighted_merge_core
    import ocwm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // class_mask[3:0], component[5:4], ref_sample_0..3[45:6], weight_ref[47:46],
    // weight_value[63:48]
    input  wire logic [63:0]        s_tdata,
    // action[0]
    input  wire logic [0:0]         s_tuser,

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // merged_sample[9:0]
    output logic [15:0]             m_tdata,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam logic signed [SUM_W-1:0] LIMIT =
        SUM_W'(((1 << SAMPLE_BITS) - 1) << WEIGHT_FRAC_BITS);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (WEIGHT_FRAC_BITS - 1));

    logic [ACT_W-1:0] active_refs_reg;

    logic                   in_action;
    refmask_t               in_mask;
    logic [COMP_W-1:0]      in_comp;
    sample_t                in_sample [NUM_REFS];
    logic [WREF_W-1:0]      in_wref;
    weight_t                in_weight;

    logic                   accept;
    logic                   comp_ok;
    logic                   wref_ok;
    refmask_t               cls_eff;
    logic [ROW_AW-1:0]      rd_row;
    logic [ROW_AW-1:0]      wr_row;
    logic                   rd_en;

    logic [ROW_DEPTH-1:0]   wvalid_reg [NUM_REFS];
    refmask_t               vrow_reg;
    logic [NUM_REFS-1:0][WEIGHT_W-1:0] rd_weight;

    logic                   v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                   ready1, ready2, ready3, ready_out;

    refmask_t               cls1_reg;
    sample_t                samp1_reg [NUM_REFS];
    logic signed [PROD_W-1:0] prod_next [NUM_REFS];
    logic signed [PROD_W-1:0] prod2_reg [NUM_REFS];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum3_reg;
    logic signed [SUM_W-1:0]  rnd;
    sample_t                out_next;
    sample_t                out_data_reg;

    // input beat decode
    always_comb
    begin
        in_action = s_tuser[0];
        in_mask   = s_tdata[3:0];
        in_comp   = s_tdata[5:4];
        for (int k = 0; k < NUM_REFS; k++)
        begin
            in_sample[k] = s_tdata[6 + k*SAMPLE_BITS +: SAMPLE_BITS];
        end
        in_wref   = s_tdata[47:46];
        in_weight = s_tdata[63:48];
    end

    assign accept  = s_tvalid && s_tready;
    assign comp_ok = int'(in_comp) < NUM_COMPONENTS;
    assign wref_ok = int'(in_wref) < NUM_REFS;
    assign cls_eff = in_mask & active_mask(active_refs_reg) & {NUM_REFS{comp_ok}};
    assign rd_row  = ROW_AW'(int'(in_comp) * NUM_CLASSES + int'(cls_eff));
    assign wr_row  = ROW_AW'(int'(in_comp) * NUM_CLASSES + int'(in_mask));
    assign rd_en   = accept && (in_action == ACT_MERGE) && comp_ok;

    // one weight ram per reference, all read at the same row
    for (genvar g = 0; g < NUM_REFS; g++)
    begin : g_ram
        logic we;
        assign we = accept && (in_action == ACT_LOAD) && comp_ok && wref_ok
                    && (int'(in_wref) == g);

        ocwm_ram #(
            .WIDTH (WEIGHT_W),
            .DEPTH (ROW_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (wr_row),
            .wdata (in_weight),
            .re    (rd_en),
            .raddr (rd_row),
            .rdata (rd_weight[g])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                wvalid_reg[g] <= '0;
            end
            else if (we)
            begin
                wvalid_reg[g][wr_row] <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rd_en)
            begin
                vrow_reg[g] <= wvalid_reg[g][rd_row];
            end
        end
    end

    // stage flow control
    assign ready_out = !out_valid_reg || m_tready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign s_tready  = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept && (in_action == ACT_MERGE);
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // multiply, sum, round and clamp
    always_comb
    begin
        for (int k = 0; k < NUM_REFS; k++)
        begin
            prod_next[k] = (cls1_reg[k] && vrow_reg[k])
                ? PROD_W'(signed'(rd_weight[k])) * PROD_W'(signed'({1'b0, samp1_reg[k]}))
                : '0;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_REFS; k++)
        begin
            sum_next = sum_next + SUM_W'(prod2_reg[k]);
        end
    end

    always_comb
    begin
        rnd = sum3_reg + HALF;
        if (sum3_reg < 0)
        begin
            out_next = '0;
        end
        else if (sum3_reg > LIMIT)
        begin
            out_next = '1;
        end
        else
        begin
            out_next = rnd[WEIGHT_FRAC_BITS +: SAMPLE_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_action == ACT_MERGE))
        begin
            cls1_reg  <= cls_eff;
            samp1_reg <= in_sample;
        end
        if (ready2 && v1_reg)
        begin
            prod2_reg <= prod_next;
        end
        if (ready3 && v2_reg)
        begin
            sum3_reg <= sum_next;
        end
        if (ready_out && v3_reg)
        begin
            out_data_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(out_data_reg);

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_refs_reg <= ACTIVE_REFS_RST;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1:2] == REG_ACTIVE_REFS))
        begin
            active_refs_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE_REFS)
                    ? PDATA_W'(active_refs_reg) : '0;

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:SAMPLE_BITS] == '0))
        else $error("merged sample padding not zero");

    a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |-> (!rd_en ##1 v1_reg))
        else $error("weight read data lost while stage one stalled");

    a_load_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_action == ACT_LOAD)) |=> !v1_reg)
        else $error("load beat entered the merge pipeline");

endmodule

`default_nettype wire
